>>> rtl/core/yv12_pixel_to_bgr24_core_macros.svh
// Assertion macros shared by the YV12 to BGR24 core.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef YV12_PIXEL_TO_BGR24_CORE_MACROS_SVH
`define YV12_PIXEL_TO_BGR24_CORE_MACROS_SVH

// same-cycle implication
`define Y2B_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define Y2B_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/y2b_pkg.sv
// Types and constants for the YV12 to BGR24 core.
// No dependencies.
`default_nettype none

package y2b_pkg;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned OFFSET_W = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SUM_W    = 26;
  localparam int unsigned PROD_W   = 25;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1080;

  // Q16 coefficients
  localparam logic [17:0] COEF_RV = 18'd89831;
  localparam logic [17:0] COEF_GU = 18'd45744;
  localparam logic [17:0] COEF_GV = 18'd46080;
  localparam logic [17:0] COEF_BU = 18'd113538;

  localparam logic [8:0] CHROMA_BIAS = 9'd128;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  function automatic logic signed [PROD_W-1:0] mul_coef(input logic [17:0] c,
                                                        input logic signed [8:0] d);
    logic signed [27:0] p;
    p = $signed({10'b0, c}) * 28'(d);
    return p[PROD_W-1:0];
  endfunction

  // truncate Q16 toward zero, clamp to 0..255
  function automatic logic [SAMPLE_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (|s[SUM_W-2:24]) begin
      r = 8'hFF;
    end else begin
      r = s[23:16];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/y2b_pix_if.sv
// Pixel input channel: valid/ready plus YV12 samples and position.
// Depends on y2b_pkg.
`default_nettype none

interface y2b_pix_if;
  logic                             valid;
  logic                             ready;
  logic [y2b_pkg::SAMPLE_W-1:0]     luma;
  logic [y2b_pkg::SAMPLE_W-1:0]     chroma_u;
  logic [y2b_pkg::SAMPLE_W-1:0]     chroma_v;
  logic [y2b_pkg::POS_W-1:0]        column;
  logic [y2b_pkg::POS_W-1:0]        row;

  modport source (output valid, luma, chroma_u, chroma_v, column, row, input ready);
  modport sink   (input valid, luma, chroma_u, chroma_v, column, row, output ready);
endinterface

`default_nettype wire

>>> rtl/core/y2b_res_if.sv
// Result channel: valid/ready plus BGR components and byte offset.
// Depends on y2b_pkg.
`default_nettype none

interface y2b_res_if;
  logic                             valid;
  logic                             ready;
  logic [y2b_pkg::SAMPLE_W-1:0]     red;
  logic [y2b_pkg::SAMPLE_W-1:0]     green;
  logic [y2b_pkg::SAMPLE_W-1:0]     blue;
  logic [y2b_pkg::OFFSET_W-1:0]     byte_offset;

  modport source (output valid, red, green, blue, byte_offset, input ready);
  modport sink   (input valid, red, green, blue, byte_offset, output ready);
endinterface

`default_nettype wire

>>> rtl/core/y2b_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Depends on y2b_pkg.
`default_nettype none

interface y2b_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [y2b_pkg::CFG_IDX_W-1:0]    index;
  logic [y2b_pkg::DIM_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/y2b_cfg.sv
// Frame size registers with saturation to the maximum dimension.
// Depends on y2b_pkg and y2b_cfg_if.
`default_nettype none

module y2b_cfg #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire             clk,
  input  wire             rst_n,
  y2b_cfg_if.sink         cfg_wr,
  output y2b_pkg::dims_t  dims
);

  localparam logic [14:0] MAX_DIM_C = 15'(MAX_DIMENSION);

  y2b_pkg::dims_t              dims_r;
  y2b_pkg::dims_t              dims_nxt;
  logic [y2b_pkg::DIM_W-1:0]   sat_val;

  assign cfg_wr.ready = 1'b1;
  assign sat_val = ({2'b0, cfg_wr.data} > MAX_DIM_C) ? MAX_DIM_C[y2b_pkg::DIM_W-1:0]
                                                     : cfg_wr.data;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        y2b_pkg::REG_FRAME_WIDTH:  dims_nxt.width  = sat_val;
        y2b_pkg::REG_FRAME_HEIGHT: dims_nxt.height = sat_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.width  <= y2b_pkg::WIDTH_RESET;
      dims_r.height <= y2b_pkg::HEIGHT_RESET;
    end else begin
      dims_r <= dims_nxt;
    end
  end

  assign dims = dims_r;

endmodule

`default_nettype wire

>>> rtl/core/yv12_pixel_to_bgr24_core.sv
// YV12 pixel to bottom-up BGR24 conversion, four-stage pipeline.
// Depends on y2b_pkg, y2b_*_if, y2b_cfg and the core macros header.
//
//   channel   role     transaction
//   in_pix    sink     luma, chroma_u, chroma_v, column, row
//   out_res   source   red, green, blue, byte_offset
//   cfg_wr    sink     index, data (always ready)
//
// One pixel per cycle sustained while out_res.ready is high; out_res.valid is the stage 4 valid bit.
// Stages: bias/line, Q16 multiplies and line*width, sums and *3, clamp/output.
// Each stage moves when its successor is empty or moving; bubbles collapse.
// Synchronous active-low reset clears valid bits; config resets to 1920x1080.
`default_nettype none

`include "yv12_pixel_to_bgr24_core_macros.svh"

module yv12_pixel_to_bgr24_core #(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire        clk,
  input  wire        rst_n,
  y2b_pix_if.sink    in_pix,
  y2b_res_if.source  out_res,
  y2b_cfg_if.sink    cfg_wr
);

  localparam int unsigned SW = y2b_pkg::SUM_W;
  localparam int unsigned PW = y2b_pkg::PROD_W;
  localparam int unsigned OW = y2b_pkg::OFFSET_W;

  y2b_pkg::dims_t dims;

  y2b_cfg #(.MAX_DIMENSION(MAX_DIMENSION)) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .dims   (dims)
  );

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1
  logic [7:0]          y1_r;
  logic signed [8:0]   du1_r, dv1_r;
  logic [OW-1:0]       line1_r;
  logic [11:0]         col1_r;
  // stage 2
  logic [7:0]          y2_r;
  logic signed [PW-1:0] rv2_r, gu2_r, gv2_r, bu2_r;
  logic [OW-1:0]       pix2_r;
  // stage 3
  logic signed [SW-1:0] r3_r, g3_r, b3_r;
  logic [OW-1:0]       off3_r;
  // stage 4 (output)
  logic [7:0]          red_r, green_r, blue_r;
  logic [OW-1:0]       off4_r;

  logic signed [SW-1:0] base2;

  assign en4 = !v4_r || out_res.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_pix.ready = en1;

  assign base2 = $signed({2'b0, y2_r, 16'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_pix.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y1_r    <= in_pix.luma;
      du1_r   <= $signed({1'b0, in_pix.chroma_u} - y2b_pkg::CHROMA_BIAS);
      dv1_r   <= $signed({1'b0, in_pix.chroma_v} - y2b_pkg::CHROMA_BIAS);
      line1_r <= OW'(dims.height) - OW'(1) - OW'(in_pix.row);
      col1_r  <= in_pix.column;
    end
    if (en2) begin
      y2_r   <= y1_r;
      rv2_r  <= y2b_pkg::mul_coef(y2b_pkg::COEF_RV, dv1_r);
      gu2_r  <= y2b_pkg::mul_coef(y2b_pkg::COEF_GU, du1_r);
      gv2_r  <= y2b_pkg::mul_coef(y2b_pkg::COEF_GV, dv1_r);
      bu2_r  <= y2b_pkg::mul_coef(y2b_pkg::COEF_BU, du1_r);
      pix2_r <= OW'(line1_r * OW'(dims.width)) + OW'(col1_r);
    end
    if (en3) begin
      r3_r   <= base2 + SW'(rv2_r);
      g3_r   <= base2 - SW'(gu2_r) - SW'(gv2_r);
      b3_r   <= base2 + SW'(bu2_r);
      off3_r <= pix2_r + {pix2_r[OW-2:0], 1'b0};
    end
    if (en4) begin
      red_r   <= y2b_pkg::to_byte(r3_r);
      green_r <= y2b_pkg::to_byte(g3_r);
      blue_r  <= y2b_pkg::to_byte(b3_r);
      off4_r  <= off3_r;
    end
  end

  assign out_res.valid       = v4_r;
  assign out_res.red         = red_r;
  assign out_res.green       = green_r;
  assign out_res.blue        = blue_r;
  assign out_res.byte_offset = off4_r;

  `Y2B_ASSERT_NXT(a_accept_lands, in_pix.valid && in_pix.ready, v1_r, "accepted pixel lost")
  `Y2B_ASSERT_IMP(a_stall_full, !in_pix.ready, v1_r && v2_r && v3_r && v4_r, "bubble under stall")
  `Y2B_ASSERT_NXT(a_s3_to_out, v3_r && en4, out_res.valid, "stage 3 result not presented")

endmodule

`default_nettype wire
